### rtl/ias_pkg.sv
// shared types for the insertion sorter: payload structs, cell control, fsm codes
`default_nettype none
package ias_pkg;

	localparam int unsigned DataWidth = 32;

	// input transfer payload
	typedef struct packed {
		logic signed [DataWidth-1:0] value;
		logic                        last_item;
	} in_t;

	// output transfer payload
	typedef struct packed {
		logic signed [DataWidth-1:0] sorted_value;
		logic                        last_result;
		logic                        overflowed;
	} out_t;

	// contents of one cell
	typedef struct packed {
		logic                        valid;
		logic signed [DataWidth-1:0] value;
	} cell_data_t;

	// command broadcast to every cell
	typedef struct packed {
		logic                        insert;
		logic                        shift;
		logic signed [DataWidth-1:0] value;
	} cell_ctrl_t;

	// control states, one-hot
	typedef enum logic [1:0] {
		ST_LOAD  = 2'b01,
		ST_DRAIN = 2'b10
	} state_t;

endpackage
`default_nettype wire

### rtl/ias_cell.sv
// one insertion cell: holds a value; new or left value on insert, right value on shift
`default_nettype none
module ias_cell (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ias_pkg::cell_ctrl_t ctrl,
	input  wire logic               left_gt,
	input  wire ias_pkg::cell_data_t left_data,
	input  wire ias_pkg::cell_data_t right_data,
	output ias_pkg::cell_data_t     data,
	output logic                    gt
);

	logic                                 valid_q;
	logic signed [ias_pkg::DataWidth-1:0] value_q;
	ias_pkg::cell_data_t                  data_q;
	ias_pkg::cell_data_t                  data_d;

	assign data_q = {valid_q, value_q};

	// new value belongs at or before this cell (empty cells count as +inf)
	assign gt = !data_q.valid || (ctrl.value < data_q.value);

	// next contents
	always_comb begin
		data_d = data_q;
		priority if (ctrl.insert) begin
			if (left_gt) begin
				data_d = left_data;
			end else if (gt) begin
				data_d.valid = 1'b1;
				data_d.value = ctrl.value;
			end
		end else if (ctrl.shift) begin
			data_d = right_data;
		end
	end

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= data_d.valid;
		end
	end

	// value, no reset
	always_ff @(posedge clk) begin
		value_q <= data_d.value;
	end

	assign data = data_q;

endmodule
`default_nettype wire

### rtl/integer_array_sorter_core.sv
// top level of the insertion sorter: cell chain, load/drain control, output register
`default_nettype none
// Sorts a set of signed 32-bit values in ascending order. Values come in one per
// transfer, one per cycle while in_ready is high, and each is placed into a chain
// of MAX_ELEMS insertion cells in the cycle it is taken. The transfer with
// last_item set starts output; from then on in_ready is low while the chain shifts
// its contents out toward the output register, one result per cycle when out_ready
// is held high. The next set may start loading while the final result of the
// previous set still waits in the output register. Values that arrive while all
// cells are full are dropped, and every result of that set carries overflowed.
module integer_array_sorter_core #(
	parameter int unsigned MAX_ELEMS = 64
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire ias_pkg::in_t  in_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output ias_pkg::out_t      out_data
);

	localparam int unsigned CntWidth = $clog2(MAX_ELEMS + 1);
	localparam logic [CntWidth-1:0] CntMax = CntWidth'(MAX_ELEMS);
	localparam logic [CntWidth-1:0] CntOne = CntWidth'(1);

	ias_pkg::state_t     state_q;
	logic [CntWidth-1:0] count_q;
	logic                ovf_q;
	logic                out_valid_q;
	ias_pkg::out_t       out_q;

	logic                in_xfer;
	logic                full;
	logic                slot_free;
	logic                do_shift;
	logic                drain_done;
	ias_pkg::cell_ctrl_t ctrl;
	ias_pkg::cell_data_t cells [MAX_ELEMS];
	logic                gts   [MAX_ELEMS];

	// handshake and chain commands
	assign in_ready   = (state_q == ias_pkg::ST_LOAD);
	assign in_xfer    = in_valid && in_ready;
	assign full       = (count_q == CntMax);
	assign slot_free  = !out_valid_q || out_ready;
	assign do_shift   = (state_q == ias_pkg::ST_DRAIN) && slot_free && (count_q != '0);
	assign drain_done = do_shift && (count_q == CntOne);

	assign ctrl.insert = in_xfer && !full;
	assign ctrl.shift  = do_shift;
	assign ctrl.value  = in_data.value;

	// cell chain
	for (genvar i = 0; i < MAX_ELEMS; i++) begin : g_cell
		ias_pkg::cell_data_t left_d;
		ias_pkg::cell_data_t right_d;
		logic                left_g;

		if (i == 0) begin : g_head
			assign left_d = '0;
			assign left_g = 1'b0;
		end else begin : g_body
			assign left_d = cells[i-1];
			assign left_g = gts[i-1];
		end

		if (i == MAX_ELEMS - 1) begin : g_tail
			assign right_d = '0;
		end else begin : g_inner
			assign right_d = cells[i+1];
		end

		ias_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.left_gt    (left_g),
			.left_data  (left_d),
			.right_data (right_d),
			.data       (cells[i]),
			.gt         (gts[i])
		);
	end

	// control state, element count, overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ias_pkg::ST_LOAD;
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ias_pkg::ST_LOAD: begin
					if (in_xfer) begin
						if (full) begin
							ovf_q <= 1'b1;
						end else begin
							count_q <= count_q + CntOne;
						end
						if (in_data.last_item) begin
							state_q <= ias_pkg::ST_DRAIN;
						end
					end
				end
				ias_pkg::ST_DRAIN: begin
					if (do_shift) begin
						count_q <= count_q - CntOne;
					end
					if (drain_done) begin
						ovf_q   <= 1'b0;
						state_q <= ias_pkg::ST_LOAD;
					end
				end
				default: begin
					state_q <= ias_pkg::ST_LOAD;
				end
			endcase
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_shift) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (do_shift) begin
			out_q.sorted_value <= cells[0].value;
			out_q.last_result  <= (count_q == CntOne);
			out_q.overflowed   <= ovf_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// head cell holds data whenever elements are counted
	a_head_valid : assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) |-> cells[0].valid)
		else $error("head cell empty while elements are held");

	// head cell is empty whenever no elements are counted, as after a set has fully drained
	a_empty_after_drain : assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> !cells[0].valid)
		else $error("head cell valid with zero count");

	// draining never runs with an empty chain
	a_drain_nonempty : assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ias_pkg::ST_DRAIN) |-> (count_q != '0))
		else $error("drain state with zero count");

	// count stays within capacity
	a_count_bound : assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntMax)
		else $error("element count above capacity");

	// the last result of a set returns the block to loading, clears overflow and is marked last
	a_last_ends_drain : assert property (@(posedge clk) disable iff (!arst_n)
		drain_done |=> (state_q == ias_pkg::ST_LOAD) && !ovf_q && out_q.last_result)
		else $error("final result did not end the set");

endmodule
`default_nettype wire

### bench/integer_array_sorter_core_test.sv
// self-checking bench for the insertion sorter: directed and random sets, stalls on both channels
module integer_array_sorter_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned Capacity   = 64;
	localparam int unsigned ClkPeriod  = 10;
	localparam int unsigned CycleLimit = 200000;
	localparam int unsigned HoldCycles = 300;
	localparam int unsigned RandomGoal = 100;

	typedef logic signed [ias_pkg::DataWidth-1:0] elem_t;

	// directed sets: single value, extremes, equal values, descending, ascending
	localparam ias_pkg::in_t DirectedItems [20] = '{
		{32'h0000_0000, 1'b1},
		{32'h7fff_ffff, 1'b0}, {32'h8000_0000, 1'b0}, {32'hffff_ffff, 1'b0},
		{32'h0000_0000, 1'b0}, {32'h0000_0001, 1'b0}, {32'h8000_0000, 1'b1},
		{32'h0000_0005, 1'b0}, {32'hffff_fffd, 1'b0}, {32'h0000_0005, 1'b0},
		{32'h0000_0005, 1'b0}, {32'hffff_fffd, 1'b1},
		{32'h0000_0003, 1'b0}, {32'h0000_0002, 1'b0}, {32'h0000_0001, 1'b0},
		{32'h0000_0000, 1'b1},
		{32'hffff_fffe, 1'b0}, {32'hffff_ffff, 1'b0}, {32'h0000_0000, 1'b0},
		{32'h7fff_fffe, 1'b1}
	};

	// predicts the sorted output of each set and checks what comes out
	class sort_scoreboard;
		int unsigned       capacity;
		elem_t             set_values[$];
		bit                set_dropped;
		ias_pkg::out_t     expected_results[$];
		int unsigned       mismatches;
		int unsigned       results_checked;
		int unsigned       sets_closed;
		int unsigned       overflow_sets;

		function new(int unsigned cap);
			capacity        = cap;
			set_dropped     = 1'b0;
			mismatches      = 0;
			results_checked = 0;
			sets_closed     = 0;
			overflow_sets   = 0;
		endfunction

		task report(string what);
			$display("MISMATCH: %s", what);
			mismatches++;
		endtask

		function int unsigned outstanding();
			return expected_results.size();
		endfunction

		// store the value unless full; on the last transfer sort and queue the set
		function void note_input(ias_pkg::in_t item);
			ias_pkg::out_t res;
			elem_t         tmp;
			int            j;
			if (set_values.size() < capacity) begin
				set_values.push_back(item.value);
			end else begin
				set_dropped = 1'b1;
			end
			if (!item.last_item)
				return;
			// insertion sort, signed
			for (int i = 1; i < set_values.size(); i++) begin
				j = i;
				while (j > 0 && set_values[j] < set_values[j-1]) begin
					tmp             = set_values[j];
					set_values[j]   = set_values[j-1];
					set_values[j-1] = tmp;
					j--;
				end
			end
			foreach (set_values[k]) begin
				res.sorted_value = set_values[k];
				res.last_result  = (k == set_values.size() - 1);
				res.overflowed   = set_dropped;
				expected_results.push_back(res);
			end
			sets_closed++;
			if (set_dropped)
				overflow_sets++;
			set_values.delete();
			set_dropped = 1'b0;
		endfunction

		// compare one accepted result with the oldest prediction
		task check_result(ias_pkg::out_t got);
			ias_pkg::out_t want;
			results_checked++;
			if (expected_results.size() == 0) begin
				report($sformatf("unexpected result value %0d last %0b overflow %0b",
					got.sorted_value, got.last_result, got.overflowed));
				return;
			end
			want = expected_results.pop_front();
			if (got.sorted_value !== want.sorted_value)
				report($sformatf("result %0d: sorted_value %0d, expected %0d",
					results_checked, got.sorted_value, want.sorted_value));
			if (got.last_result !== want.last_result)
				report($sformatf("result %0d: last_result %0b, expected %0b",
					results_checked, got.last_result, want.last_result));
			if (got.overflowed !== want.overflowed)
				report($sformatf("result %0d: overflowed %0b, expected %0b",
					results_checked, got.overflowed, want.overflowed));
		endtask
	endclass

	logic          clk = 1'b0;
	logic          arst_n;
	logic          in_valid;
	logic          in_ready;
	ias_pkg::in_t  in_data;
	logic          out_valid;
	logic          out_ready;
	ias_pkg::out_t out_data;

	sort_scoreboard board = new(Capacity);

	bit          calm         = 1'b0;
	int unsigned hold_request = 0;
	int unsigned item_count   = 0;
	int unsigned random_items = 0;
	int unsigned cycle_count  = 0;

	integer_array_sorter_core #(
		.MAX_ELEMS(Capacity)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	// free-running clock
	always #(ClkPeriod/2) clk = ~clk;

	function automatic int unsigned draw_gap(bit no_idle);
		return no_idle ? 0 : $urandom_range(0, 9);
	endfunction

	// half full-range values, the rest extremes and a narrow band for duplicates
	function automatic elem_t draw_value();
		case ($urandom_range(0, 7))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7fff_ffff;
			2, 3:    return elem_t'(int'($urandom_range(0, 6)) - 3);
			default: return elem_t'($urandom);
		endcase
	endfunction

	// one input transfer after an optional idle gap
	task automatic send_item(ias_pkg::in_t item, int unsigned gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		do @(posedge clk); while (!in_ready);
		board.note_input(item);
		item_count++;
	endtask

	// one set of random values, last transfer marked
	task automatic send_random_set(int unsigned size, bit burst);
		ias_pkg::in_t item;
		calm = burst;
		for (int unsigned k = 0; k < size; k++) begin
			item.value     = draw_value();
			item.last_item = (k == size - 1);
			send_item(item, draw_gap(burst));
			random_items++;
		end
	endtask

	task automatic wait_drained();
		while (board.outstanding() != 0) @(posedge clk);
	endtask

	// receiver: random gaps, long hold on request
	initial begin : receiver
		int unsigned wait_left;
		wait_left = 0;
		forever begin
			if (hold_request != 0) begin
				wait_left    = hold_request;
				hold_request = 0;
			end
			out_ready <= (wait_left == 0);
			@(posedge clk);
			if (out_ready && out_valid) begin
				board.check_result(out_data);
				wait_left = draw_gap(calm);
			end else if (wait_left > 0) begin
				wait_left--;
			end
		end
	end

	// watchdog
	initial begin : watchdog
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		board.report($sformatf("timeout after %0d cycles, %0d results still expected",
			cycle_count, board.outstanding()));
		$display("Simulation FAILED");
		$finish;
	end

	// stimulus and end of run
	initial begin : stimulus
		arst_n   = 1'b0;
		in_valid = 1'b0;
		in_data  = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed sets
		foreach (DirectedItems[k])
			send_item(DirectedItems[k], draw_gap(1'b0));

		// small random sets, some without idling
		while (random_items < 10)
			send_random_set($urandom_range(1, 12), $urandom_range(0, 3) == 0);

		// sender pauses until drained, then an overfull set back to back while the
		// receiver holds: extra values dropped, last one included
		in_valid <= 1'b0;
		wait_drained();
		hold_request = HoldCycles;
		send_random_set(Capacity + $urandom_range(1, 4), 1'b1);
		send_random_set(4, 1'b1);

		while (random_items < RandomGoal)
			send_random_set($urandom_range(1, 12), $urandom_range(0, 3) == 0);

		in_valid <= 1'b0;
		wait_drained();
		repeat (2 * Capacity + 10) @(posedge clk);

		$display("covered %0d sets from %0d transfers, %0d results checked, %0d with overflow",
			board.sets_closed, item_count, board.results_checked, board.overflow_sets);
		$display("mismatches: %0d, cycles: %0d", board.mismatches, cycle_count);
		if (board.mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

### files.f
rtl/ias_pkg.sv
rtl/ias_cell.sv
rtl/integer_array_sorter_core.sv
bench/integer_array_sorter_core_test.sv
